>>> sv/jeig_pkg.sv
// Package for the 3x3 symmetric Jacobi eigen solver.
// Holds the request and result structs, the sequencer states and shared constants.
// No dependencies.
`default_nettype none
package jeig_pkg;

  // Matrix entries are held in Q16.16 inside a 36-bit accumulator
  localparam int ACC_W   = 36;
  localparam int VEC_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAX_ROT = 32;

  localparam logic signed [37:0] ACC_LIM = 38'sd17179869183;  // 2^34 - 1
  localparam logic signed [37:0] VEC_ONE = 38'sd1073741824;   // 2^30 in Q2.30

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_ROT_LIMIT = 2'd1
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PICK,
    ST_TH_DIV,
    ST_TH_SQ,
    ST_TH_ROOT,
    ST_TM_DIV,
    ST_TM_SQ,
    ST_R2_ROOT,
    ST_CM_DIV,
    ST_SM_MUL,
    ST_SM_GET,
    ST_TP_MUL,
    ST_TP_GET,
    ST_PAIR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] a_xx;
    logic signed [31:0] a_yy;
    logic signed [31:0] a_zz;
    logic signed [31:0] a_xy;
    logic signed [31:0] a_xz;
    logic signed [31:0] a_yz;
  } matrix_t;

  typedef struct packed {
    logic signed [31:0] eig_a;
    logic signed [31:0] eig_b;
    logic signed [31:0] eig_c;
    logic signed [31:0] vec_a_x;
    logic signed [31:0] vec_a_y;
    logic signed [31:0] vec_a_z;
    logic signed [31:0] vec_b_x;
    logic signed [31:0] vec_b_y;
    logic signed [31:0] vec_b_z;
    logic signed [31:0] vec_c_x;
    logic signed [31:0] vec_c_y;
    logic signed [31:0] vec_c_z;
  } result_t;

endpackage
`default_nettype wire

>>> sv/jacobi_eigen_3x3_symmetric.sv
// Jacobi eigen solver for a symmetric 3x3 matrix, Q16.16 in, Q16.16/Q2.30 out.
// One shared multiplier, a bit-serial divider and a bit-serial square root under a sequencer.
// Depends on jeig_pkg.
// Each request runs at most 32 rotations; the rotation limit is capped at MAX_ROT.
// Each rotation: pivot pick, three divisions, two square roots and the shared-multiplier steps.
// One request at a time; busy drops in the done cycle.
// done marks the result for exactly one cycle; the receiver cannot stall.
// Synchronous reset: threshold 1, rotation limit 32, sequencer idle.
`default_nettype none
module jacobi_eigen_3x3_symmetric (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  jeig_pkg::matrix_t      matrix,
  output logic                   done,
  output jeig_pkg::result_t      result,
  input  wire                    cfg_we,
  input  wire  [1:0]             cfg_index,
  input  wire  [30:0]            cfg_data
);

  // clamp a 38-bit signed value to +-lim
  function automatic logic signed [37:0] clamp(input logic signed [37:0] x,
                                               input logic signed [37:0] lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic logic [34:0] mag36(input logic signed [35:0] x);
    logic [35:0] m;
    m = x[35] ? 36'(-x) : 36'(x);
    return m[34:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    if (x > 36'sd2147483647) return 32'sh7fffffff;
    if (x < -36'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  jeig_pkg::state_t state, state_next;

  // configuration
  logic [30:0] thr;
  logic [5:0]  rot_limit;

  // working matrix and eigenvectors
  logic signed [35:0] d [3];
  logic signed [35:0] o [3];
  logic signed [31:0] v [3][3];

  logic [6:0] cnt;
  logic [5:0] it;
  logic [1:0] grp;
  logic [1:0] p, q, opq, orp, orq;
  logic       neg;
  logic [34:0] am;
  logic [35:0] diffmag;
  logic [30:0] th, tm, cm, sm;

  // divider
  logic [63:0] dvd;
  logic [34:0] rem, den;
  // square root
  logic [63:0] sx, sr, sbit;
  // multiplier
  logic [34:0] mul_a;
  logic [30:0] mul_b;
  logic        mul_s;
  logic [65:0] mul_p;
  logic        mul_neg;
  logic signed [37:0] acc0, acc1;

  // rounded signed product from the last multiply
  logic [65:0] rnd_sum;
  logic signed [37:0] rprod;
  assign rnd_sum = mul_p + 66'd536870912;
  assign rprod   = mul_neg ? -$signed({2'b00, rnd_sum[65:30]}) : $signed({2'b00, rnd_sum[65:30]});

  // largest off-diagonal search
  logic [34:0] m0, m1, m2, mx;
  logic [1:0]  sel;
  logic [5:0]  lim;
  logic        stop;
  always_comb begin
    m0 = mag36(o[0]);
    m1 = mag36(o[1]);
    m2 = mag36(o[2]);
    sel = 2'd0;
    mx = m0;
    if (m1 > mx) begin
      sel = 2'd1;
      mx = m1;
    end
    if (m2 > mx) begin
      sel = 2'd2;
      mx = m2;
    end
    lim = (rot_limit > 6'(jeig_pkg::MAX_ROT)) ? 6'(jeig_pkg::MAX_ROT) : rot_limit;
    stop = (it == lim) || (mx < {4'd0, thr}) || (mx == '0);
  end

  // saturated theta straight from the divider
  logic [30:0] th_sat;
  assign th_sat = (dvd > 64'd2147483647) ? 31'h7fffffff : dvd[30:0];

  // pair operands: group 0 is the off-diagonal pair, groups 1..3 the vector rows
  logic [1:0] krow;
  logic signed [35:0] xp, xq;
  assign krow = grp - 2'd1;
  always_comb begin
    if (grp == 2'd0) begin
      xp = o[orp];
      xq = o[orq];
    end else begin
      xp = 36'(v[krow][p]);
      xq = 36'(v[krow][q]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      jeig_pkg::ST_IDLE:    if (start) state_next = jeig_pkg::ST_PICK;
      jeig_pkg::ST_PICK:    state_next = stop ? jeig_pkg::ST_DONE : jeig_pkg::ST_TH_DIV;
      jeig_pkg::ST_TH_DIV:  if (cnt == 7'd64) state_next = jeig_pkg::ST_TH_SQ;
      jeig_pkg::ST_TH_SQ:   state_next = jeig_pkg::ST_TH_ROOT;
      jeig_pkg::ST_TH_ROOT: if (cnt == 7'd32) state_next = jeig_pkg::ST_TM_DIV;
      jeig_pkg::ST_TM_DIV:  if (cnt == 7'd64) state_next = jeig_pkg::ST_TM_SQ;
      jeig_pkg::ST_TM_SQ:   state_next = jeig_pkg::ST_R2_ROOT;
      jeig_pkg::ST_R2_ROOT: if (cnt == 7'd32) state_next = jeig_pkg::ST_CM_DIV;
      jeig_pkg::ST_CM_DIV:  if (cnt == 7'd64) state_next = jeig_pkg::ST_SM_MUL;
      jeig_pkg::ST_SM_MUL:  state_next = jeig_pkg::ST_SM_GET;
      jeig_pkg::ST_SM_GET:  state_next = jeig_pkg::ST_TP_MUL;
      jeig_pkg::ST_TP_MUL:  state_next = jeig_pkg::ST_TP_GET;
      jeig_pkg::ST_TP_GET:  state_next = jeig_pkg::ST_PAIR;
      jeig_pkg::ST_PAIR:    if (cnt == 7'd4 && grp == 2'd3) state_next = jeig_pkg::ST_PICK;
      jeig_pkg::ST_DONE:    state_next = jeig_pkg::ST_IDLE;
      default:              state_next = jeig_pkg::ST_IDLE;
    endcase
  end

  // outputs: multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_s = 1'b0;
    unique case (state)
      jeig_pkg::ST_TH_SQ: begin
        mul_a = 35'(th_sat);
        mul_b = th_sat;
      end
      jeig_pkg::ST_TM_SQ: begin
        mul_a = 35'(dvd[30:0]);
        mul_b = dvd[30:0];
      end
      jeig_pkg::ST_SM_MUL: begin
        mul_a = 35'(tm);
        mul_b = dvd[30:0];
      end
      jeig_pkg::ST_TP_MUL: begin
        mul_a = am;
        mul_b = tm;
        mul_s = o[opq][35] ^ neg;
      end
      jeig_pkg::ST_PAIR: begin
        case (cnt)
          7'd0: begin
            mul_a = mag36(xp); mul_b = cm; mul_s = xp[35];
          end
          7'd1: begin
            mul_a = mag36(xq); mul_b = sm; mul_s = xq[35] ^ neg;
          end
          7'd2: begin
            mul_a = mag36(xp); mul_b = sm; mul_s = xp[35] ^ neg;
          end
          7'd3: begin
            mul_a = mag36(xq); mul_b = cm; mul_s = xq[35];
          end
          default: begin
            mul_a = '0; mul_b = '0; mul_s = 1'b0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        mul_s = 1'b0;
      end
    endcase
  end

  assign busy = (state != jeig_pkg::ST_IDLE);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jeig_pkg::ST_IDLE;
      cnt       <= '0;
      it        <= '0;
      grp       <= '0;
      done      <= 1'b0;
      thr       <= 31'd1;
      rot_limit <= 6'd32;
    end else begin
      state <= state_next;
      done  <= (state == jeig_pkg::ST_DONE);
      if (state_next != state || (state == jeig_pkg::ST_PAIR && cnt == 7'd4)) cnt <= '0;
      else cnt <= cnt + 7'd1;
      if (state == jeig_pkg::ST_IDLE) it <= '0;
      else if (state == jeig_pkg::ST_PAIR && cnt == 7'd4 && grp == 2'd3) it <= it + 6'd1;
      if (state == jeig_pkg::ST_TP_GET) grp <= '0;
      else if (state == jeig_pkg::ST_PAIR && cnt == 7'd4) grp <= grp + 2'd1;
      if (cfg_we && !busy) begin
        if (cfg_index == jeig_pkg::CFG_THRESHOLD) thr <= cfg_data;
        else if (cfg_index == jeig_pkg::CFG_ROT_LIMIT) rot_limit <= cfg_data[5:0];
      end
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    mul_p   <= 66'(mul_a) * 66'(mul_b);
    mul_neg <= mul_s;
  end

  // divider: 64 restoring steps, one quotient bit per cycle
  logic [35:0] trial;
  assign trial = {rem, dvd[63]};
  always_ff @(posedge clk) begin
    if ((state == jeig_pkg::ST_TH_DIV || state == jeig_pkg::ST_TM_DIV ||
         state == jeig_pkg::ST_CM_DIV) && cnt == 7'd0) begin
      rem <= '0;
      if (state == jeig_pkg::ST_TH_DIV) begin
        dvd <= {13'd0, diffmag, 15'd0} + 64'(am >> 1);
        den <= am;
      end else if (state == jeig_pkg::ST_TM_DIV) begin
        dvd <= 64'h0000_4000_0000_0000 + ((64'(th) + sr) >> 1);
        den <= 35'(64'(th) + sr);
      end else begin
        dvd <= 64'h1000_0000_0000_0000 + (sr >> 1);
        den <= 35'(sr);
      end
    end else if (state == jeig_pkg::ST_TH_DIV || state == jeig_pkg::ST_TM_DIV ||
                 state == jeig_pkg::ST_CM_DIV) begin
      if (trial >= {1'b0, den}) begin
        rem <= 35'(trial - {1'b0, den});
        dvd <= {dvd[62:0], 1'b1};
      end else begin
        rem <= trial[34:0];
        dvd <= {dvd[62:0], 1'b0};
      end
    end
  end

  // square root: 32 steps, two radicand bits per cycle
  logic [63:0] srb;
  assign srb = sr + sbit;
  always_ff @(posedge clk) begin
    if ((state == jeig_pkg::ST_TH_ROOT || state == jeig_pkg::ST_R2_ROOT) && cnt == 7'd0) begin
      sx   <= (state == jeig_pkg::ST_TH_ROOT) ? mul_p[63:0] + 64'h1_0000_0000
                                              : mul_p[63:0] + 64'h1000_0000_0000_0000;
      sr   <= '0;
      sbit <= 64'h4000_0000_0000_0000;
    end else if (state == jeig_pkg::ST_TH_ROOT || state == jeig_pkg::ST_R2_ROOT) begin
      if (sx >= srb) begin
        sx <= sx - srb;
        sr <= (sr >> 1) + sbit;
      end else begin
        sr <= sr >> 1;
      end
      sbit <= sbit >> 2;
    end
  end

  // matrix, rotation terms and result
  logic signed [37:0] diff;
  logic signed [37:0] wb_p, wb_q;
  assign diff = 38'(d[q]) - 38'(d[p]);
  // magnitude of aqq - app, ready for the theta divider load
  assign diffmag = diff[37] ? 36'(-diff) : 36'(diff);
  always_comb begin
    if (grp == 2'd0) begin
      wb_p = clamp(acc0, jeig_pkg::ACC_LIM);
      wb_q = clamp(acc1 + rprod, jeig_pkg::ACC_LIM);
    end else begin
      wb_p = clamp(acc0, jeig_pkg::VEC_ONE);
      wb_q = clamp(acc1 + rprod, jeig_pkg::VEC_ONE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      jeig_pkg::ST_IDLE: begin
        if (start) begin
          d[0] <= 36'(matrix.a_xx);
          d[1] <= 36'(matrix.a_yy);
          d[2] <= 36'(matrix.a_zz);
          o[0] <= 36'(matrix.a_xy);
          o[1] <= 36'(matrix.a_xz);
          o[2] <= 36'(matrix.a_yz);
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              v[i][j] <= (i == j) ? 32'sh4000_0000 : 32'sd0;
            end
          end
        end
      end
      jeig_pkg::ST_PICK: begin
        opq <= sel;
        case (sel)
          2'd0: begin p <= 2'd0; q <= 2'd1; orp <= 2'd1; orq <= 2'd2; end
          2'd1: begin p <= 2'd0; q <= 2'd2; orp <= 2'd0; orq <= 2'd2; end
          default: begin p <= 2'd1; q <= 2'd2; orp <= 2'd0; orq <= 2'd1; end
        endcase
        am <= mx;
      end
      jeig_pkg::ST_TH_DIV: begin
        // sign of aqq - app against apq, taken once p and q are settled
        if (cnt == 7'd0) begin
          neg <= (diff != '0) && (diff[37] != o[opq][35]);
        end
      end
      jeig_pkg::ST_TH_SQ: th <= th_sat;
      jeig_pkg::ST_TM_SQ: tm <= dvd[30:0];
      jeig_pkg::ST_SM_MUL: cm <= dvd[30:0];
      jeig_pkg::ST_SM_GET: sm <= rnd_sum[60:30];
      jeig_pkg::ST_TP_GET: begin
        d[p]   <= 36'(clamp(38'(d[p]) - rprod, jeig_pkg::ACC_LIM));
        d[q]   <= 36'(clamp(38'(d[q]) + rprod, jeig_pkg::ACC_LIM));
        o[opq] <= '0;
      end
      jeig_pkg::ST_PAIR: begin
        case (cnt)
          7'd1: acc0 <= rprod;
          7'd2: acc0 <= acc0 - rprod;
          7'd3: acc1 <= rprod;
          7'd4: begin
            if (grp == 2'd0) begin
              o[orp] <= 36'(wb_p);
              o[orq] <= 36'(wb_q);
            end else begin
              v[krow][p] <= 32'(wb_p);
              v[krow][q] <= 32'(wb_q);
            end
          end
          default: acc1 <= acc1;
        endcase
      end
      jeig_pkg::ST_DONE: begin
        result.eig_a   <= sat32(d[0]);
        result.eig_b   <= sat32(d[1]);
        result.eig_c   <= sat32(d[2]);
        result.vec_a_x <= v[0][0];
        result.vec_a_y <= v[1][0];
        result.vec_a_z <= v[2][0];
        result.vec_b_x <= v[0][1];
        result.vec_b_y <= v[1][1];
        result.vec_b_z <= v[2][1];
        result.vec_c_x <= v[0][2];
        result.vec_c_y <= v[1][2];
        result.vec_c_z <= v[2][2];
      end
      default: acc0 <= acc0;
    endcase
  end

  // checks
  a_done_from_done_state: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == jeig_pkg::ST_DONE)) else $error("done without finish");
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_rot_bound: assert property (@(posedge clk) disable iff (rst)
    it <= 6'(jeig_pkg::MAX_ROT)) else $error("rotation count overrun");
  a_pair_step: assert property (@(posedge clk) disable iff (rst)
    (state == jeig_pkg::ST_PAIR) |-> cnt <= 7'd4) else $error("pair step overrun");
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    (state == jeig_pkg::ST_TH_DIV && cnt == 7'd1) |-> den != '0) else $error("zero divisor");

endmodule
`default_nettype wire
